@@ sv/spectrum_magnitude_smoother_unit_assert.svh @@
// Assertion macros for the spectrum magnitude smoother.
`ifndef SPECTRUM_MAGNITUDE_SMOOTHER_UNIT_ASSERT_SVH
`define SPECTRUM_MAGNITUDE_SMOOTHER_UNIT_ASSERT_SVH

// Checked on every clock edge outside reset.
`define SMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SMS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ sv/sms_pkg.sv @@
package sms_pkg;

  localparam int unsigned PointCount = 512;
  localparam int unsigned FftShift   = 10;
  localparam int unsigned AddrW      = $clog2(PointCount);

  localparam int unsigned IdxW   = 9;
  localparam int unsigned BinW   = 24;
  localparam int unsigned SqW    = 2 * BinW - 1;   // |x|^2 <= 2^46
  localparam int unsigned SumW   = SqW + 1;
  localparam int unsigned RadW   = SumW + 16;      // radicand carries 16 fraction bits
  localparam int unsigned RootW  = RadW / 2;
  localparam int unsigned RemW   = RootW + 2;
  localparam int unsigned MagW   = RootW - FftShift;
  localparam int unsigned StoreW = 30;
  localparam int unsigned TauW   = 17;
  localparam int unsigned GainW  = 16;
  localparam int unsigned ValW   = 32;

  localparam int unsigned SqSteps = 4;             // root bits per stage
  localparam int unsigned SqStages = RootW / SqSteps;

  localparam logic [TauW-1:0]  TauOne    = TauW'(65536);
  localparam logic [TauW-1:0]  TauReset  = TauW'(52429);
  localparam logic [GainW-1:0] GainReset = GainW'(2125);

  // register map, index taken from paddr[2]
  localparam logic RegTau  = 1'b0;
  localparam logic RegGain = 1'b1;

  typedef struct packed {
    logic            vld;
    logic            inr;
    logic [IdxW-1:0] idx;
  } meta_t;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sq_part_t;

  typedef struct packed {
    logic [RadW-1:0] rad;
    sq_part_t        part;
  } sq_stage_t;

  // one restoring square-root step: brings down two radicand bits
  function automatic sq_part_t sqrt_step(sq_part_t cur, logic [1:0] pair);
    logic [RemW+1:0] rem_sh;
    logic [RemW+1:0] trial;
    sq_part_t        nxt;
    rem_sh = {cur.rem, pair};
    trial  = {{(RemW - RootW){1'b0}}, cur.root, 2'b01};
    if (rem_sh >= trial) begin
      nxt.rem  = RemW'(rem_sh - trial);
      nxt.root = {cur.root[RootW-2:0], 1'b1};
    end else begin
      nxt.rem  = RemW'(rem_sh);
      nxt.root = {cur.root[RootW-2:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage

@@ sv/sms_isqrt.sv @@
module sms_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  sms_pkg::meta_t               meta_i,
  input  logic [sms_pkg::RadW-1:0]     rad_i,
  output sms_pkg::meta_t               meta_o,
  output logic [sms_pkg::RootW-1:0]    root_o
);
  import sms_pkg::*;

  sq_stage_t st_q   [SqStages];
  meta_t     meta_q [SqStages];

  for (genvar g = 0; g < SqStages; g++) begin : g_stage
    sq_stage_t st_in;
    sq_stage_t st_d;
    meta_t     meta_in;

    if (g == 0) begin : g_first
      assign st_in   = '{rad: rad_i, part: '0};
      assign meta_in = meta_i;
    end else begin : g_next
      assign st_in   = st_q[g-1];
      assign meta_in = meta_q[g-1];
    end

    always_comb begin
      st_d = st_in;
      for (int s = 0; s < SqSteps; s++) begin
        st_d.part = sqrt_step(st_d.part, st_d.rad[RadW-1 -: 2]);
        st_d.rad  = {st_d.rad[RadW-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        meta_q[g] <= '0;
      end else if (en_i) begin
        meta_q[g] <= meta_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[g] <= st_d;
      end
    end
  end

  assign meta_o = meta_q[SqStages-1];
  assign root_o = st_q[SqStages-1].part.root;

endmodule

@@ sv/spectrum_magnitude_smoother_unit.sv @@
// Pipeline: 16 register stages.
// Throughput: one transaction per cycle unless a held output or the interlock stalls.
// A point index equal to that of a valid item in the first two stages stalls input
// until that item has left them (store read-modify-write interlock).
// Reset: async, active low; then a pass over all 512 points zeroes the smoothed store
// and s_axis_tready stays low until it is done. Config registers take their reset values.
module spectrum_magnitude_smoother_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [8:0] point_index, [32:9] bin_real, [56:33] bin_imag
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // [8:0] point_out, [40:9] display_value
  // APB config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sms_pkg::*;

  `include "spectrum_magnitude_smoother_unit_assert.svh"

  localparam int unsigned PsW   = StoreW + TauW;
  localparam int unsigned PmW   = MagW + TauW;
  localparam int unsigned SsumW = PsW + 1;
  localparam int unsigned GmW   = GainW + StoreW;
  localparam int unsigned VW    = GmW + 1 - 8;

  localparam logic [SsumW-1:0] RoundS   = SsumW'(32768);
  localparam logic [GmW:0]     RoundV   = (GmW + 1)'(128);
  localparam logic [StoreW-1:0] StoreMax = '1;

  // ---------------------------------------------------------------------------
  // Configuration registers. tau above one is clamped once here, so the datapath
  // only sees tau and (1 - tau) already in range.
  // ---------------------------------------------------------------------------
  logic [TauW-1:0]  tau_q, tau_eff_q, omt_q;
  logic [GainW-1:0] gain_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tau_q     <= TauReset;
      gain_q    <= GainReset;
      tau_eff_q <= TauReset;
      omt_q     <= TauOne - TauReset;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[2])
          RegTau:  tau_q  <= pwdata[TauW-1:0];
          RegGain: gain_q <= pwdata[GainW-1:0];
          default: ;
        endcase
      end
      tau_eff_q <= (tau_q > TauOne) ? TauOne : tau_q;
      omt_q     <= (tau_q > TauOne) ? '0 : TauOne - tau_q;
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegTau:  prdata = 32'(tau_q);
      RegGain: prdata = 32'(gain_q);
      default: prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. All stages advance together; only a held output stalls.
  // ---------------------------------------------------------------------------
  logic            pipe_en;
  logic            out_vld_q;
  logic            hazard;
  logic            in_acc;
  logic            clr_busy_q;
  logic [AddrW-1:0] clr_addr_q;

  logic [IdxW-1:0] in_idx;
  logic [BinW-1:0] in_re, in_im;

  assign in_idx = s_axis_tdata[8:0];
  assign in_re  = s_axis_tdata[32:9];
  assign in_im  = s_axis_tdata[56:33];

  meta_t p1_meta_q, p2_meta_q, p3_meta_q, sq_meta, rd_meta_q, mu_meta_q, wb_meta_q, gm_meta_q;

  assign pipe_en = !out_vld_q || m_axis_tready;

  // The store is read at the sqrt output stage and written two stages later,
  // so an item may not follow one of the same point by fewer than three slots.
  assign hazard = (p1_meta_q.vld && (p1_meta_q.idx == in_idx)) ||
                  (p2_meta_q.vld && (p2_meta_q.idx == in_idx));

  assign s_axis_tready = pipe_en && !clr_busy_q && !hazard;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Stage 1: magnitudes of the components
  logic [BinW-1:0] p1_re_q, p1_im_q;
  // Stage 2: squares
  logic [SqW-1:0]  p2_sqr_q, p2_sqi_q;
  logic [2*BinW-1:0] sqr_full, sqi_full;
  // Stage 3: sum of squares
  logic [SumW-1:0] p3_sum_q;

  assign sqr_full = {{BinW{1'b0}}, p1_re_q} * {{BinW{1'b0}}, p1_re_q};
  assign sqi_full = {{BinW{1'b0}}, p1_im_q} * {{BinW{1'b0}}, p1_im_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_meta_q <= '0;
      p2_meta_q <= '0;
      p3_meta_q <= '0;
    end else if (pipe_en) begin
      p1_meta_q.vld <= in_acc;
      p1_meta_q.inr <= ({1'b0, in_idx} < (IdxW + 1)'(PointCount));
      p1_meta_q.idx <= in_idx;
      p2_meta_q     <= p1_meta_q;
      p3_meta_q     <= p2_meta_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      p1_re_q  <= in_re[BinW-1] ? (~in_re + BinW'(1)) : in_re;
      p1_im_q  <= in_im[BinW-1] ? (~in_im + BinW'(1)) : in_im;
      p2_sqr_q <= sqr_full[SqW-1:0];
      p2_sqi_q <= sqi_full[SqW-1:0];
      p3_sum_q <= SumW'(p2_sqr_q) + SumW'(p2_sqi_q);
    end
  end

  // Stages 4..11: pipelined square root of the Q.16 radicand (root in Q.8)
  logic [RootW-1:0] sq_root;

  sms_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .meta_i (p3_meta_q),
    .rad_i  ({p3_sum_q, 16'h0000}),
    .meta_o (sq_meta),
    .root_o (sq_root)
  );

  // ---------------------------------------------------------------------------
  // Smoothed store: read at the sqrt output, written from the multiply stage.
  // ---------------------------------------------------------------------------
  logic [StoreW-1:0] smag_mem_q [PointCount];
  logic [StoreW-1:0] rd_s_q;
  logic [MagW-1:0]   rd_mag_q;
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [StoreW-1:0] mem_wdata;
  logic [StoreW-1:0] s_new;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      rd_s_q <= smag_mem_q[sq_meta.idx[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      smag_mem_q[mem_waddr] <= mem_wdata;
    end
  end

  assign mem_we    = clr_busy_q || (pipe_en && mu_meta_q.vld && mu_meta_q.inr);
  assign mem_waddr = clr_busy_q ? clr_addr_q : mu_meta_q.idx[AddrW-1:0];
  assign mem_wdata = clr_busy_q ? '0 : s_new;

  // zeroing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == AddrW'(PointCount - 1)) begin
        clr_busy_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + AddrW'(1);
    end
  end

  // Stage 12: old value and new magnitude; stage 13: weighted products
  logic [PsW-1:0]   mu_ps_q;
  logic [PmW-1:0]   mu_pm_q;
  logic [SsumW-1:0] s_sum;
  logic [SsumW-17:0] s_shr;
  // Stage 14: updated value; stage 15: gain product
  logic [StoreW-1:0] wb_s_q;
  logic [GmW-1:0]    gm_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_meta_q <= '0;
      mu_meta_q <= '0;
      wb_meta_q <= '0;
      gm_meta_q <= '0;
    end else if (pipe_en) begin
      rd_meta_q <= sq_meta;
      mu_meta_q <= rd_meta_q;
      wb_meta_q <= mu_meta_q;
      gm_meta_q <= wb_meta_q;
    end
  end

  // round half up, clamp to the store width
  assign s_sum = SsumW'(mu_ps_q) + SsumW'(mu_pm_q) + RoundS;
  assign s_shr = s_sum[SsumW-1:16];
  assign s_new = (|s_shr[SsumW-17:StoreW]) ? StoreMax : s_shr[StoreW-1:0];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      rd_mag_q  <= sq_root[RootW-1:FftShift];
      mu_ps_q   <= PsW'(rd_s_q) * PsW'(tau_eff_q);
      mu_pm_q   <= PmW'(rd_mag_q) * PmW'(omt_q);
      wb_s_q    <= s_new;
      gm_prod_q <= GmW'(gain_q) * GmW'(wb_s_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 16: rounding, sign by point parity, saturation; the output register.
  // ---------------------------------------------------------------------------
  logic [GmW:0]      v_sum;
  logic [VW-1:0]     v;
  logic [ValW-1:0]   val_d;
  logic [ValW-1:0]   out_val_q;
  logic [IdxW-1:0]   out_idx_q;

  assign v_sum = (GmW + 1)'(gm_prod_q) + RoundV;
  assign v     = v_sum[GmW:8];

  always_comb begin
    priority if (!gm_meta_q.inr) begin
      val_d = '0;
    end else if (gm_meta_q.idx[0]) begin
      val_d = (v >= VW'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000 : (~v[ValW-1:0] + ValW'(1));
    end else begin
      val_d = (v > VW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : v[ValW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (pipe_en) begin
      out_vld_q <= gm_meta_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      out_idx_q <= gm_meta_q.idx;
      out_val_q <= val_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'b0, out_val_q, out_idx_q};

  // ---------------------------------------------------------------------------
  // Checks: store read-modify-write ordering and clear pass exclusivity.
  // ---------------------------------------------------------------------------
  `SMS_ASSERT(a_no_raw_rd_mu, (sq_meta.vld && mu_meta_q.vld) |-> (sq_meta.idx != mu_meta_q.idx), "store read overlaps pending write two ahead")
  `SMS_ASSERT(a_no_raw_rd_rd, (sq_meta.vld && rd_meta_q.vld) |-> (sq_meta.idx != rd_meta_q.idx), "store read overlaps pending write one ahead")
  `SMS_ASSERT(a_no_raw_mu, (rd_meta_q.vld && mu_meta_q.vld) |-> (rd_meta_q.idx != mu_meta_q.idx), "stale store value entering update")
  `SMS_ASSERT(a_clear_idle, clr_busy_q |-> !(p1_meta_q.vld || mu_meta_q.vld || out_vld_q), "item in flight during store clear")
  `SMS_ASSERT(a_out_src, $rose(out_vld_q) |-> $past(gm_meta_q.vld), "output valid without a source item")

endmodule

@@ test/tb_spectrum_magnitude_smoother_unit.sv @@
`timescale 1ns / 1ps

import sms_pkg::*;

// one bin on the input stream, one display value on the output stream
typedef struct packed {
  logic [IdxW-1:0] point;
  logic [BinW-1:0] re;
  logic [BinW-1:0] im;
} bin_item_t;

typedef struct packed {
  logic [IdxW-1:0] point;
  logic [ValW-1:0] value;
} point_value_t;

// Tracks the smoothed store and the two registers, predicts each display value.
class smoother_scoreboard;
  logic [StoreW-1:0] smoothed [PointCount];
  logic [TauW-1:0]   tau_q16;
  logic [GainW-1:0]  gain_q8;
  point_value_t      expected_q [$];
  int unsigned       fails;

  function new();
    foreach (smoothed[i]) smoothed[i] = '0;
    tau_q16 = TauReset;
    gain_q8 = GainReset;
    fails   = 0;
  endfunction

  function void set_reg(logic reg_sel, logic [31:0] value);
    if (reg_sel == RegTau) begin
      tau_q16 = value[TauW-1:0];
    end else begin
      gain_q8 = value[GainW-1:0];
    end
  endfunction

  // floor square root, one result bit per pass from the top
  function logic [31:0] floor_root(logic [63:0] x);
    logic [31:0] root;
    logic [63:0] cand;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      cand = {32'b0, root | (32'd1 << b)};
      if (cand * cand <= x) root = cand[31:0];
    end
    return root;
  endfunction

  function void note_bin(bin_item_t b);
    logic [63:0]  re_w, im_w, re_a, im_a, mag, tau, s, v;
    point_value_t r;
    re_w = {{(64 - BinW){b.re[BinW-1]}}, b.re};
    im_w = {{(64 - BinW){b.im[BinW-1]}}, b.im};
    re_a = re_w[63] ? -re_w : re_w;
    im_a = im_w[63] ? -im_w : im_w;
    r.point = b.point;
    r.value = '0;
    if (b.point < PointCount) begin
      mag = 64'(floor_root((re_a * re_a + im_a * im_a) << 16)) >> FftShift;
      tau = (tau_q16 > TauOne) ? 64'(TauOne) : 64'(tau_q16);
      s = (64'(smoothed[b.point]) * tau + (64'(TauOne) - tau) * mag + 64'd32768) >> 16;
      if (s > (64'd1 << StoreW) - 64'd1) s = (64'd1 << StoreW) - 64'd1;
      smoothed[b.point] = StoreW'(s);
      v = (64'(gain_q8) * s + 64'd128) >> 8;
      // odd points are shown negated
      if (b.point[0]) begin
        if (v > 64'h8000_0000) v = 64'h8000_0000;
        r.value = ValW'(-v);
      end else begin
        if (v > 64'h7FFF_FFFF) v = 64'h7FFF_FFFF;
        r.value = ValW'(v);
      end
    end
    expected_q.push_back(r);
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  function void check_point(point_value_t got);
    point_value_t want;
    if (expected_q.size() == 0) begin
      fails++;
      if (fails <= 10)
        $display("unexpected output: point %0d value %0d", got.point, $signed(got.value));
      return;
    end
    want = expected_q.pop_front();
    if (got.point !== want.point || got.value !== want.value) begin
      fails++;
      if (fails <= 10)
        $display("mismatch: point exp %0d got %0d, value exp %0d got %0d",
                 want.point, got.point, $signed(want.value), $signed(got.value));
    end
  endfunction
endclass

module tb_spectrum_magnitude_smoother_unit;

  localparam logic [BinW-1:0] BinMax = {1'b0, {(BinW - 1){1'b1}}};
  localparam logic [BinW-1:0] BinMin = {1'b1, {(BinW - 1){1'b0}}};
  localparam logic [31:0]     TauTop = 32'((1 << TauW) - 1);
  localparam logic [31:0]     GainTop = 32'((1 << GainW) - 1);

  // idle plan per random phase: sender gap chance, receiver stall chance (percent)
  localparam int unsigned SendIdlePlan [3] = '{25, 64, 0};
  localparam int unsigned RecvStallPlan [3] = '{64, 25, 0};
  localparam int unsigned SegmentItems = 167;
  localparam int unsigned LongHoldCycles = 400;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // [8:0] point_index, [32:9] bin_real, [56:33] bin_imag
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // [8:0] point_out, [40:9] display_value
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  smoother_scoreboard sb = new();

  int unsigned     send_idle_pct;
  int unsigned     recv_stall_pct;
  int unsigned     hold_req;       // long receiver hold, picked up by the sink process
  logic [IdxW-1:0] last_point;

  spectrum_magnitude_smoother_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop; a correct run needs a small fraction of this
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Sink: checks every output transaction, then decides tready for the next edge.
  // Outputs are sampled right at the edge, before the block's own updates land.
  initial begin
    int unsigned  hold_left;
    point_value_t got;
    m_axis_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.point = m_axis_tdata[IdxW-1:0];
        got.value = m_axis_tdata[IdxW +: ValW];
        sb.check_point(got);
      end
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end else if (hold_left != 0) begin
        hold_left--;
      end
      m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one bin and hold it until accepted; the prediction is made at acceptance.
  // tvalid is only dropped when a gap follows, so back-to-back items keep it high.
  task automatic send_bin(logic [IdxW-1:0] point, logic [BinW-1:0] re, logic [BinW-1:0] im);
    bin_item_t b;
    b.point = point;
    b.re    = re;
    b.im    = im;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= 64'({b.im, b.re, b.point});
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_bin(b);
    last_point = point;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // setup then access; psel stays up so writes can go back to back
  task automatic apb_write(logic reg_sel, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(reg_sel, value);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Registers change only with the pipe empty: every item yields a result,
  // so an empty expectation queue means nothing is in flight.
  task automatic retune(logic [31:0] tau, logic [31:0] gain);
    drain_results();
    apb_write(RegTau, tau);
    apb_write(RegGain, gain);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // random points, a small hot set, repeats to hit the store interlock, the top two points and zero
  function automatic logic [IdxW-1:0] pick_point();
    case ($urandom_range(9))
      0, 1, 2, 3: return IdxW'($urandom);
      4, 5, 6:    return IdxW'($urandom_range(7));
      7:          return last_point;
      8:          return IdxW'(PointCount - 1 - $urandom_range(1));
      default:    return '0;
    endcase
  endfunction

  function automatic logic [BinW-1:0] pick_component();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return BinW'($urandom);
      6:                return BinW'(int'($urandom_range(510)) - 255);
      7:                return $urandom_range(1) ? BinMax : BinMin;
      8:                return '0;
      default:          return BinW'(int'($urandom_range(8190)) - 4095);
    endcase
  endfunction

  // tau: none, exactly one, just above one, top of the field, reset, or random
  function automatic logic [31:0] pick_tau();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 32'(TauOne);
      2:       return TauTop;
      3:       return 32'(TauOne) + 32'd1;
      4:       return 32'(TauReset);
      default: return 32'($urandom_range(65536));
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(5))
      0:       return '0;
      1:       return GainTop;
      2:       return 32'(GainReset);
      default: return 32'($urandom_range(65535));
    endcase
  endfunction

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    send_idle_pct  = SendIdlePlan[0];
    recv_stall_pct = RecvStallPlan[0];
    hold_req       = 0;
    last_point     = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset register values first. The block clears its store after
    // reset and holds tready low meanwhile; send_bin simply waits it out.
    send_bin(9'd0, BinMin, BinMin);            // largest magnitude, even point
    send_bin(9'd1, BinMax, BinMin);            // odd point comes out negated
    send_bin(9'd511, BinMax, BinMax);          // top point
    send_bin(9'd510, '0, '0);                  // zero bin
    send_bin(9'd2, 24'd1, '0);                 // below one display step
    send_bin(9'd3, '1, '1);
    send_bin(9'd5, 24'd1000, -24'sd2000);      // same point back to back: interlock
    send_bin(9'd5, 24'd1000, -24'sd2000);
    send_bin(9'd5, 24'd1000, -24'sd2000);
    send_bin(9'd4, BinMin, '0);
    send_bin(9'd6, '0, BinMax);
    send_bin(9'd4, '0, BinMax);

    // tau of exactly one: stores hold, input ignored; largest gain
    retune(32'(TauOne), GainTop);
    send_bin(9'd0, '0, '0);
    send_bin(9'd1, 24'd123, 24'd456);
    // tau above one saturates to one
    retune(TauTop, 32'd256);
    send_bin(9'd0, BinMax, BinMax);
    send_bin(9'd5, '0, '0);
    // no smoothing, zero gain
    retune('0, '0);
    send_bin(9'd0, BinMin, BinMin);
    send_bin(9'd1, BinMax, BinMax);
    // no smoothing, largest gain
    retune('0, GainTop);
    send_bin(9'd0, BinMin, BinMin);
    send_bin(9'd511, BinMin, BinMin);

    // Random part: three idle plans, each split into register settings. One
    // segment per plan starts with a long sink hold so the pipe backs up into
    // the input while the sender keeps offering.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = SendIdlePlan[phase];
      recv_stall_pct = RecvStallPlan[phase];
      for (int seg = 0; seg < 4; seg++) begin
        retune(pick_tau(), pick_gain());
        if (seg == 1) hold_req = LongHoldCycles;
        for (int n = 0; n < SegmentItems; n++)
          send_bin(pick_point(), pick_component(), pick_component());
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/sms_pkg.sv
sv/sms_isqrt.sv
sv/spectrum_magnitude_smoother_unit.sv
test/tb_spectrum_magnitude_smoother_unit.sv
